FILE: rtl/core/alpf_pkg.sv
package alpf_pkg;

   localparam int ANGLE_IN_W  = 17;
   localparam int ANGLE_OUT_W = 15;
   localparam int GAIN_W      = 17;
   localparam int ANG_W       = 32;
   localparam int ARC_IDX_W   = 5;

   localparam logic signed [ANGLE_IN_W-1:0] FULL_TURN    = 17'sd23040;
   localparam logic signed [ANGLE_IN_W-1:0] QUARTER_TURN = 17'sd5760;
   localparam logic signed [ANGLE_IN_W-1:0] HALF_TURN    = 17'sd11520;
   localparam logic signed [ANGLE_IN_W-1:0] THREE_QUARTER_TURN = 17'sd17280;

   localparam logic [ANGLE_OUT_W-1:0] FULL_TURN_OUT = 15'd23040;

   // CORDIC angle unit: 2^-22 degree
   localparam logic signed [ANG_W-1:0] ANG_HALF   = 32'sd754974720;
   localparam logic signed [ANG_W-1:0] ANG_FULL   = 32'sd1509949440;
   localparam logic signed [ANG_W-1:0] ANG_ROUND  = 32'sd32768;

   localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd6554;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_IN,
      OP_WRAP,
      OP_ROT_INIT,
      OP_STEP,
      OP_MUL_SIN,
      OP_UPD_SIN,
      OP_MUL_COS,
      OP_UPD_COS,
      OP_VEC_INIT,
      OP_FIX_Z,
      OP_ROUND
   } op_type;

   typedef struct packed {
      op_type op;
      logic   rotate;
   } cmd_type;

   typedef struct packed {
      logic angle_ok;
   } status_type;

   // atan(2^-i) in 2^-22 degree
   function automatic logic signed [ANG_W-1:0] arc_angle(input logic [ARC_IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] t;
      unique case (idx)
         5'd0:  t = 32'sd188743680;
         5'd1:  t = 32'sd111421900;
         5'd2:  t = 32'sd58872272;
         5'd3:  t = 32'sd29884485;
         5'd4:  t = 32'sd15000234;
         5'd5:  t = 32'sd7507429;
         5'd6:  t = 32'sd3754631;
         5'd7:  t = 32'sd1877430;
         5'd8:  t = 32'sd938729;
         5'd9:  t = 32'sd469366;
         5'd10: t = 32'sd234683;
         5'd11: t = 32'sd117342;
         5'd12: t = 32'sd58671;
         5'd13: t = 32'sd29335;
         5'd14: t = 32'sd14668;
         5'd15: t = 32'sd7334;
         5'd16: t = 32'sd3667;
         5'd17: t = 32'sd1833;
         5'd18: t = 32'sd917;
         5'd19: t = 32'sd458;
         5'd20: t = 32'sd229;
         5'd21: t = 32'sd115;
         5'd22: t = 32'sd57;
         5'd23: t = 32'sd29;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/core/alpf_ctrl.sv
module alpf_ctrl #(
   parameter int CORDIC_STEPS = 16,
   parameter int STEP_W       = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output alpf_pkg::cmd_type     cmd,
   output logic [STEP_W-1:0]     step,
   input  alpf_pkg::status_type  status
);
   import alpf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WRAP,
      S_ROT_INIT,
      S_ROT_STEP,
      S_MUL_SIN,
      S_UPD_SIN,
      S_MUL_COS,
      S_UPD_COS,
      S_VEC_INIT,
      S_VEC_STEP,
      S_FIX_Z,
      S_ROUND
   } state_type;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   state_type         state_ff;
   logic              rsp_valid_ff;
   logic [STEP_W-1:0] step_ff;
   logic              out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign step      = step_ff;

   always_comb begin
      cmd.op     = OP_NONE;
      cmd.rotate = 1'b0;
      unique case (state_ff)
         S_IDLE:     if (req_valid) cmd.op = OP_LOAD_IN;
         S_WRAP:     if (!status.angle_ok) cmd.op = OP_WRAP;
         S_ROT_INIT: cmd.op = OP_ROT_INIT;
         S_ROT_STEP: begin
            cmd.op     = OP_STEP;
            cmd.rotate = 1'b1;
         end
         S_MUL_SIN:  cmd.op = OP_MUL_SIN;
         S_UPD_SIN:  cmd.op = OP_UPD_SIN;
         S_MUL_COS:  cmd.op = OP_MUL_COS;
         S_UPD_COS:  cmd.op = OP_UPD_COS;
         S_VEC_INIT: cmd.op = OP_VEC_INIT;
         S_VEC_STEP: cmd.op = OP_STEP;
         S_FIX_Z:    cmd.op = OP_FIX_Z;
         S_ROUND:    if (out_free) cmd.op = OP_ROUND;
         default:    cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (state_ff == S_ROUND && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE:     if (req_valid) state_ff <= S_WRAP;
            S_WRAP:     if (status.angle_ok) state_ff <= S_ROT_INIT;
            S_ROT_INIT: begin
               step_ff  <= '0;
               state_ff <= S_ROT_STEP;
            end
            S_ROT_STEP: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) state_ff <= S_MUL_SIN;
            end
            S_MUL_SIN:  state_ff <= S_UPD_SIN;
            S_UPD_SIN:  state_ff <= S_MUL_COS;
            S_MUL_COS:  state_ff <= S_UPD_COS;
            S_UPD_COS:  state_ff <= S_VEC_INIT;
            S_VEC_INIT: begin
               step_ff  <= '0;
               state_ff <= S_VEC_STEP;
            end
            S_VEC_STEP: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) state_ff <= S_FIX_Z;
            end
            S_FIX_Z:    state_ff <= S_ROUND;
            S_ROUND: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/core/alpf_datapath.sv
module alpf_datapath #(
   parameter int VECTOR_FRAC_BITS = 16,
   parameter int STEP_W           = 4
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  alpf_pkg::cmd_type                         cmd,
   input  logic [STEP_W-1:0]                         step,
   output alpf_pkg::status_type                      status,
   input  logic signed [alpf_pkg::ANGLE_IN_W-1:0]    req_angle_in,
   output logic [alpf_pkg::ANGLE_OUT_W-1:0]          rsp_angle_out,
   input  logic                                      csr_write_enable,
   input  logic [alpf_pkg::GAIN_W-1:0]               csr_write_data
);
   import alpf_pkg::*;

   localparam int F  = VECTOR_FRAC_BITS;
   localparam int VW = F + 3;   // CORDIC vector
   localparam int SW = F + 2;   // filter state
   localparam int PW = F + 21;  // gain * difference
   localparam int CW = F + 6;   // state update sum

   localparam longint GAIN_SH    = 30 - F;
   localparam longint INV_GAIN_L = (64'sd652032874 + ((64'sd1 <<< GAIN_SH) >>> 1)) >>> GAIN_SH;
   localparam logic signed [VW-1:0] INV_GAIN = VW'(INV_GAIN_L);
   localparam logic signed [CW-1:0] UNIT_POS = CW'(64'sd1 <<< F);
   localparam logic signed [CW-1:0] UNIT_NEG = -UNIT_POS;
   localparam logic signed [PW-1:0] PROD_ROUND = PW'(32768);

   function automatic logic signed [SW-1:0] clamp_unit(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] r;
      if (v > UNIT_POS) r = UNIT_POS;
      else if (v < UNIT_NEG) r = UNIT_NEG;
      else r = v;
      return r[SW-1:0];
   endfunction

   logic signed [ANGLE_IN_W-1:0]  angle_ff, angle_in;
   logic signed [VW-1:0]          x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0]       z_ff, z_in;
   logic signed [SW-1:0]          sine_ff, sine_in, cosine_ff, cosine_in;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic [GAIN_W-1:0]             gain_ff;
   logic                          zero_ff, zero_in;
   logic [ANGLE_OUT_W-1:0]        out_ff, out_in;

   logic signed [VW-1:0]          dx, dy, xs, ys, diff;
   logic signed [ANG_W-1:0]       t, zr;
   logic                          ccw;
   logic signed [ANGLE_IN_W-1:0]  zs;
   logic [GAIN_W-1:0]             g_eff;
   logic signed [SW-1:0]          comp, st;
   logic signed [PW-1:0]          rounded;
   logic signed [CW-1:0]          upd_sum;
   logic [ANGLE_OUT_W-1:0]        r;

   assign status.angle_ok = !angle_ff[ANGLE_IN_W-1] && (angle_ff < FULL_TURN);
   assign rsp_angle_out   = out_ff;

   assign g_eff = (gain_ff > GAIN_ONE) ? GAIN_ONE : gain_ff;

   assign dx  = y_ff >>> step;
   assign dy  = x_ff >>> step;
   assign t   = arc_angle(ARC_IDX_W'(step));
   assign ccw = cmd.rotate ? !z_ff[ANG_W-1] : y_ff[VW-1];

   assign xs = VW'(cosine_ff);
   assign ys = VW'(sine_ff);

   always_comb begin
      if (cmd.op == OP_MUL_SIN) begin
         comp = clamp_unit(CW'(y_ff));
         st   = sine_ff;
      end else begin
         comp = clamp_unit(CW'(x_ff));
         st   = cosine_ff;
      end
   end
   assign diff    = VW'(comp) - VW'(st);
   assign prod_in = PW'($signed({1'b0, g_eff})) * PW'(diff);
   assign rounded = (prod_ff + PROD_ROUND) >>> 16;
   assign upd_sum = CW'((cmd.op == OP_UPD_SIN) ? sine_ff : cosine_ff)
                    + $signed(rounded[CW-1:0]);

   assign zr = z_ff + ANG_ROUND;
   assign r  = zr[ANGLE_OUT_W+15:16];

   always_comb begin
      if (angle_ff > QUARTER_TURN && angle_ff <= THREE_QUARTER_TURN) zs = angle_ff - HALF_TURN;
      else if (angle_ff > THREE_QUARTER_TURN) zs = angle_ff - FULL_TURN;
      else zs = angle_ff;
   end

   always_comb begin
      angle_in  = angle_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      sine_in   = sine_ff;
      cosine_in = cosine_ff;
      zero_in   = zero_ff;
      out_in    = out_ff;
      unique case (cmd.op)
         OP_LOAD_IN: angle_in = req_angle_in;
         OP_WRAP: begin
            if (angle_ff[ANGLE_IN_W-1]) angle_in = angle_ff + FULL_TURN;
            else angle_in = angle_ff - FULL_TURN;
         end
         OP_ROT_INIT: begin
            x_in = (angle_ff > QUARTER_TURN && angle_ff <= THREE_QUARTER_TURN)
                   ? -INV_GAIN : INV_GAIN;
            y_in = '0;
            z_in = {zs[15:0], 16'b0};
         end
         OP_STEP: begin
            if (ccw) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - t;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + t;
            end
         end
         OP_UPD_SIN: sine_in   = clamp_unit(upd_sum);
         OP_UPD_COS: cosine_in = clamp_unit(upd_sum);
         OP_VEC_INIT: begin
            zero_in = (xs == '0) && (ys == '0);
            if (xs[VW-1]) begin
               x_in = -xs;
               y_in = -ys;
               z_in = ANG_HALF;
            end else begin
               x_in = xs;
               y_in = ys;
               z_in = '0;
            end
         end
         OP_FIX_Z: if (z_ff[ANG_W-1]) z_in = z_ff + ANG_FULL;
         OP_ROUND: begin
            if (zero_ff) out_in = '0;
            else if (r >= FULL_TURN_OUT) out_in = r - FULL_TURN_OUT;
            else out_in = r;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sine_ff   <= '0;
         cosine_ff <= '0;
         gain_ff   <= GAIN_RESET;
      end else begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
         if (csr_write_enable) gain_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      zero_ff  <= zero_in;
      out_ff   <= out_in;
      if (cmd.op == OP_MUL_SIN || cmd.op == OP_MUL_COS) prod_ff <= prod_in;
   end

endmodule

FILE: rtl/core/angle_low_pass_filter_core.sv
// channel   | ports                                  | role
// ----------+----------------------------------------+--------------------------------
// request   | req_valid, req_ready, req_angle_in     | heading in, 1/64 degree, signed
// response  | rsp_valid, rsp_ready, rsp_angle_out    | filtered heading, 0..23039
// csr       | csr_write_enable, csr_write_data       | smoothing gain, Q1.16
//
// One beat at a time: the input angle is first wrapped into one turn, then one shared
// CORDIC stage runs once for sine and cosine and once for atan2, one step per cycle,
// with the shared multiplier used between the two runs for both filter updates.
// Reset (synchronous) clears both filter states to zero and loads the gain with 6554.
// A finished result waits in the output register; a new request is taken meanwhile and
// only the final rounding cycle stalls while rsp_ready holds off.
module angle_low_pass_filter_core #(
   parameter int CORDIC_STEPS     = 16,
   parameter int VECTOR_FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [alpf_pkg::ANGLE_IN_W-1:0] req_angle_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [alpf_pkg::ANGLE_OUT_W-1:0]       rsp_angle_out,
   input  logic                                   csr_write_enable,
   input  logic [alpf_pkg::GAIN_W-1:0]            csr_write_data
);
   import alpf_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);

   cmd_type           cmd;
   status_type        status;
   logic [STEP_W-1:0] step;

   alpf_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .STEP_W       (STEP_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .step      (step),
      .status    (status)
   );

   alpf_datapath #(
      .VECTOR_FRAC_BITS (VECTOR_FRAC_BITS),
      .STEP_W           (STEP_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .step             (step),
      .status           (status),
      .req_angle_in     (req_angle_in),
      .rsp_angle_out    (rsp_angle_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_out < FULL_TURN_OUT)
      else $error("filtered heading outside one turn");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a beat is in flight");

   a_round_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_ROUND |=> rsp_valid)
      else $error("result rounded but not presented");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (cmd.op == OP_NONE || cmd.op == OP_LOAD_IN))
      else $error("datapath busy while idle");

endmodule
